// ===== hdl/rgb_led_pulse_encoder_top_defines.svh =====
// Assertion helpers shared by the encoder modules.
`ifndef RGB_LED_PULSE_ENCODER_TOP_DEFINES_SVH
`define RGB_LED_PULSE_ENCODER_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define RLPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Trigger in one cycle implies the consequence in the next cycle.
`define RLPE_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> cons) else $error(msg);

`endif

// ===== hdl/rlpe_pkg.sv =====
package rlpe_pkg;

  // Stream geometry.
  localparam int unsigned BITS_PER_LED    = 24;
  localparam int unsigned PAUSE_SLOTS_DEF = 50;
  localparam int unsigned SLOT_W          = 6;
  localparam int unsigned IDX_W           = 5;

  // Brightness mapping: angle = percent * 45 / 100, clamped to 45 degrees.
  localparam logic [7:0]  PERCENT_FULL = 8'd100;
  localparam logic [5:0]  ANGLE_MAX    = 6'd45;
  localparam logic [13:0] ANGLE_MUL    = 14'd45;
  // Reciprocals for the constant divisions, both followed by a 19-bit shift.
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam logic [17:0] DIV3_RECIP   = 18'd174763;

  // Register indexes (byte address bit 2).
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_PERIOD     = 1'b1;

  // Reset values of the registers and the values derived from them.
  localparam logic [7:0]  BRIGHTNESS_RST = 8'd100;
  localparam logic [16:0] PERIOD_RST     = 17'd90;
  localparam logic [16:0] FACTOR_RST     = 17'd65536;
  localparam logic [15:0] DUTY_ZERO_RST  = 16'd30;
  localparam logic [15:0] DUTY_ONE_RST   = 16'd60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_led;
  } in_word_t;

  typedef struct packed {
    logic [15:0]       duty;
    logic [SLOT_W-1:0] slot_count;
    logic              run_last;
  } out_word_t;

  // One classified LED: scaled GRB word plus frame end flag.
  typedef struct packed {
    logic [BITS_PER_LED-1:0] grb;
    logic                    last_led;
  } led_item_t;

  // Settings derived at register write time.
  typedef struct packed {
    logic [16:0] factor;
    logic [15:0] duty_zero;
    logic [15:0] duty_one;
  } cfg_t;

  // tan(angle degrees) in Q1.16, rounded to nearest.
  function automatic logic [16:0] tan_q16(input logic [5:0] angle);
    logic [16:0] f;
    case (angle)
      6'd0:  f = 17'd0;      6'd1:  f = 17'd1144;   6'd2:  f = 17'd2289;
      6'd3:  f = 17'd3435;   6'd4:  f = 17'd4583;   6'd5:  f = 17'd5734;
      6'd6:  f = 17'd6888;   6'd7:  f = 17'd8047;   6'd8:  f = 17'd9210;
      6'd9:  f = 17'd10380;  6'd10: f = 17'd11556;  6'd11: f = 17'd12739;
      6'd12: f = 17'd13930;  6'd13: f = 17'd15130;  6'd14: f = 17'd16340;
      6'd15: f = 17'd17560;  6'd16: f = 17'd18792;  6'd17: f = 17'd20036;
      6'd18: f = 17'd21294;  6'd19: f = 17'd22566;  6'd20: f = 17'd23853;
      6'd21: f = 17'd25157;  6'd22: f = 17'd26478;  6'd23: f = 17'd27818;
      6'd24: f = 17'd29179;  6'd25: f = 17'd30560;  6'd26: f = 17'd31964;
      6'd27: f = 17'd33392;  6'd28: f = 17'd34846;  6'd29: f = 17'd36327;
      6'd30: f = 17'd37837;  6'd31: f = 17'd39378;  6'd32: f = 17'd40951;
      6'd33: f = 17'd42560;  6'd34: f = 17'd44205;  6'd35: f = 17'd45889;
      6'd36: f = 17'd47615;  6'd37: f = 17'd49385;  6'd38: f = 17'd51202;
      6'd39: f = 17'd53070;  6'd40: f = 17'd54991;  6'd41: f = 17'd56970;
      6'd42: f = 17'd59009;  6'd43: f = 17'd61113;  6'd44: f = 17'd63287;
      6'd45: f = 17'd65536;
      default: f = 17'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/rlpe_cfg.sv =====
module rlpe_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output rlpe_pkg::cfg_t      cfg
);

  logic [7:0]  brightness_r, brightness_nxt;
  logic [16:0] period_r, period_nxt;
  logic [16:0] factor_r, factor_nxt;
  logic [15:0] duty_zero_r, duty_zero_nxt;
  logic [15:0] duty_one_r, duty_one_nxt;

  logic        wr_en;
  logic        reg_sel;
  logic [7:0]  pct;
  logic [13:0] pct_scaled;
  logic [26:0] angle_prod;
  logic [5:0]  angle;
  logic [16:0] period_in;
  logic [35:0] zero_prod;
  logic [35:0] one_prod;
  logic [16:0] zero_q;
  logic [16:0] one_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Brightness to angle: multiply by 45, divide by 100 through a reciprocal.
  assign pct        = pwdata[7:0];
  assign pct_scaled = {6'd0, pct} * rlpe_pkg::ANGLE_MUL;
  assign angle_prod = {13'd0, pct_scaled} * {14'd0, rlpe_pkg::DIV100_RECIP};
  assign angle      = (pct > rlpe_pkg::PERCENT_FULL) ? rlpe_pkg::ANGLE_MAX
                                                     : angle_prod[24:19];

  // Period thirds through a reciprocal multiply; exact over the 17-bit range.
  assign period_in = pwdata[16:0];
  assign zero_prod = {19'd0, period_in} * {18'd0, rlpe_pkg::DIV3_RECIP};
  assign one_prod  = {18'd0, period_in, 1'b0} * {18'd0, rlpe_pkg::DIV3_RECIP};
  assign zero_q    = zero_prod[35:19];
  assign one_q     = one_prod[35:19];

  // Register writes; derived values are captured with the raw value.
  always_comb begin
    brightness_nxt = brightness_r;
    period_nxt     = period_r;
    factor_nxt     = factor_r;
    duty_zero_nxt  = duty_zero_r;
    duty_one_nxt   = duty_one_r;
    if (wr_en) begin
      case (reg_sel)
        rlpe_pkg::REG_BRIGHTNESS: begin
          brightness_nxt = pct;
          factor_nxt     = rlpe_pkg::tan_q16(angle);
        end
        rlpe_pkg::REG_PERIOD: begin
          period_nxt    = period_in;
          duty_zero_nxt = zero_q[16] ? 16'hFFFF : zero_q[15:0];
          duty_one_nxt  = one_q[16] ? 16'hFFFF : one_q[15:0];
        end
        default: begin
          brightness_nxt = brightness_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= rlpe_pkg::BRIGHTNESS_RST;
      period_r     <= rlpe_pkg::PERIOD_RST;
      factor_r     <= rlpe_pkg::FACTOR_RST;
      duty_zero_r  <= rlpe_pkg::DUTY_ZERO_RST;
      duty_one_r   <= rlpe_pkg::DUTY_ONE_RST;
    end else begin
      brightness_r <= brightness_nxt;
      period_r     <= period_nxt;
      factor_r     <= factor_nxt;
      duty_zero_r  <= duty_zero_nxt;
      duty_one_r   <= duty_one_nxt;
    end
  end

  // Read back.
  assign prdata = (reg_sel == rlpe_pkg::REG_BRIGHTNESS) ? {24'd0, brightness_r}
                                                        : {15'd0, period_r};

  assign cfg.factor    = factor_r;
  assign cfg.duty_zero = duty_zero_r;
  assign cfg.duty_one  = duty_one_r;

endmodule

// ===== hdl/rlpe_front.sv =====
module rlpe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  rlpe_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlpe_pkg::in_word_t  in_data,
  output logic                fq_valid,
  input  logic                fq_ready,
  output rlpe_pkg::led_item_t fq_item
);

  logic                valid_r, valid_nxt;
  rlpe_pkg::led_item_t item_r, item_nxt;
  logic                accept;
  logic [24:0]         red_prod;
  logic [24:0]         green_prod;
  logic [24:0]         blue_prod;

  // Scale each channel by the Q1.16 factor, truncating.
  assign red_prod   = {17'd0, in_data.red} * {8'd0, cfg.factor};
  assign green_prod = {17'd0, in_data.green} * {8'd0, cfg.factor};
  assign blue_prod  = {17'd0, in_data.blue} * {8'd0, cfg.factor};

  assign in_ready = !valid_r || fq_ready;
  assign accept   = in_valid && in_ready;

  // Holding register in front of the queue.
  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt         = 1'b1;
      item_nxt.grb      = {green_prod[23:16], red_prod[23:16], blue_prod[23:16]};
      item_nxt.last_led = in_data.last_led;
    end else if (fq_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign fq_valid = valid_r;
  assign fq_item  = item_r;

endmodule

// ===== hdl/rlpe_queue.sv =====
`include "rgb_led_pulse_encoder_top_defines.svh"

module rlpe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  rlpe_pkg::led_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output rlpe_pkg::led_item_t pop_item
);

  localparam logic [1:0] DEPTH = 2'd2;

  rlpe_pkg::led_item_t entries_r [2];
  logic [1:0]          count_r, count_nxt;
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic                push;
  logic                pop;

  assign push_ready = (count_r != DEPTH);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  `RLPE_ASSERT(a_count_range, clk, rst_n, count_r <= DEPTH, "queue fill out of range")
  `RLPE_ASSERT(a_ptr_match, clk, rst_n, (count_r == 2'd0 || count_r == DEPTH) |-> wr_ptr_r == rd_ptr_r, "queue pointers disagree with fill")

endmodule

// ===== hdl/rlpe_back.sv =====
`include "rgb_led_pulse_encoder_top_defines.svh"

module rlpe_back #(
  parameter int unsigned PAUSE_SLOTS = rlpe_pkg::PAUSE_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlpe_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  rlpe_pkg::led_item_t  q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rlpe_pkg::out_word_t  out_data
);

  localparam int unsigned SLOT_MAX = (1 << rlpe_pkg::SLOT_W) - 1;
  localparam logic [rlpe_pkg::SLOT_W-1:0] PAUSE_CNT =
    (PAUSE_SLOTS > SLOT_MAX) ? rlpe_pkg::SLOT_W'(SLOT_MAX)
                             : rlpe_pkg::SLOT_W'(PAUSE_SLOTS);
  localparam logic [rlpe_pkg::IDX_W-1:0] PAUSE_IDX =
    rlpe_pkg::IDX_W'(rlpe_pkg::BITS_PER_LED);
  localparam logic [rlpe_pkg::IDX_W-1:0] LAST_BIT_IDX =
    rlpe_pkg::IDX_W'(rlpe_pkg::BITS_PER_LED - 1);
  localparam logic [rlpe_pkg::IDX_W-1:0] IDX_STEP = rlpe_pkg::IDX_W'(1);

  logic                              cur_valid_r, cur_valid_nxt;
  logic [rlpe_pkg::BITS_PER_LED-1:0] cur_word_r, cur_word_nxt;
  logic [rlpe_pkg::IDX_W-1:0]        cur_idx_r, cur_idx_nxt;
  logic                              cur_last_r, cur_last_nxt;
  logic                              out_valid_r, out_valid_nxt;
  rlpe_pkg::out_word_t               out_data_r, out_data_nxt;
  rlpe_pkg::out_word_t               res;
  logic                              is_pause;
  logic                              final_res;
  logic                              emit;
  logic                              done;
  logic                              load;

  assign is_pause  = (cur_idx_r == PAUSE_IDX);
  assign final_res = is_pause || ((cur_idx_r == LAST_BIT_IDX) && !cur_last_r);
  assign emit      = cur_valid_r && (!out_valid_r || out_ready);
  assign done      = emit && final_res;
  assign q_ready   = !cur_valid_r || done;
  assign load      = q_ready && q_valid;

  // Result for the current slot: MSB of the shifting word, or the pause.
  always_comb begin
    if (is_pause) begin
      res.duty       = 16'd0;
      res.slot_count = PAUSE_CNT;
    end else begin
      res.duty       = cur_word_r[rlpe_pkg::BITS_PER_LED-1] ? cfg.duty_one
                                                            : cfg.duty_zero;
      res.slot_count = rlpe_pkg::SLOT_W'(1);
    end
    res.run_last = final_res;
  end

  // Bit sequencer.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_word_nxt  = cur_word_r;
    cur_idx_nxt   = cur_idx_r;
    cur_last_nxt  = cur_last_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      cur_word_nxt  = q_item.grb;
      cur_idx_nxt   = '0;
      cur_last_nxt  = q_item.last_led;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      cur_word_nxt = {cur_word_r[rlpe_pkg::BITS_PER_LED-2:0], 1'b0};
      cur_idx_nxt  = cur_idx_r + IDX_STEP;
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_word_r <= cur_word_nxt;
    cur_idx_r  <= cur_idx_nxt;
    cur_last_r <= cur_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RLPE_ASSERT(a_idx_range, clk, rst_n, cur_valid_r |-> cur_idx_r <= PAUSE_IDX, "slot index past the pause")
  `RLPE_ASSERT(a_pause_only_last, clk, rst_n, (cur_valid_r && is_pause) |-> cur_last_r, "pause on an LED that does not end the frame")
  `RLPE_ASSERT_NEXT(a_final_shown, clk, rst_n, done, out_valid_r && out_data_r.run_last, "final word of an LED not presented")

endmodule

// ===== hdl/rgb_led_pulse_encoder_top.sv =====
// RGB LED pulse encoder.
// Input channel (in_valid/in_ready/in_data): one word per LED with red, green,
// blue and a last_led flag. Output channel (out_valid/out_ready/out_data): one
// word per bit slot with a timer compare value (duty), a slot count and
// run_last, which marks the final word caused by an input word.
// Each LED gives 24 words in GRB order, most significant bit first; an LED
// with last_led set gives a 25th word, the pause (duty 0 for PAUSE_SLOTS, capped at 63).
// Registers on the APB port: brightness_percent at 0x0, period_ticks at 0x4.
// Brightness factor and duty values are computed when the register is written.
// When the encoder is empty, an LED that is taken passes through the holding
// register, the queue, the bit sequencer and the output register. Throughput:
// one output word per cycle while the receiver is ready and LEDs are waiting;
// the bit sequencer in the back end, which emits one slot per cycle, sets this rate.
// A holding register and a two-entry queue let new LEDs be taken while the
// back end is busy or the receiver stalls; a stall simply holds the output.
// Reset empties all stages and sets brightness 100 and period 90.
module rgb_led_pulse_encoder_top #(
  parameter int unsigned PAUSE_SLOTS = rlpe_pkg::PAUSE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rlpe_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rlpe_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  rlpe_pkg::cfg_t      cfg;
  logic                fq_valid;
  logic                fq_ready;
  rlpe_pkg::led_item_t fq_item;
  logic                bq_valid;
  logic                bq_ready;
  rlpe_pkg::led_item_t bq_item;

  rlpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .fq_valid (fq_valid),
    .fq_ready (fq_ready),
    .fq_item  (fq_item)
  );

  rlpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_item   (bq_item)
  );

  rlpe_back #(
    .PAUSE_SLOTS (PAUSE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (bq_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== test/rgb_led_pulse_encoder_top_tb.sv =====
module rgb_led_pulse_encoder_top_tb;

  localparam int unsigned PAUSE_LEN    = rlpe_pkg::PAUSE_SLOTS_DEF;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASES       = 8;

  // Byte addresses of the two registers.
  localparam logic [2:0] ADDR_BRIGHTNESS = {rlpe_pkg::REG_BRIGHTNESS, 2'b00};
  localparam logic [2:0] ADDR_PERIOD     = {rlpe_pkg::REG_PERIOD, 2'b00};

  // Tangent of 0..45 degrees in Q1.16, rounded to nearest.
  localparam int unsigned TANGENT_Q16 [0:45] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
    11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294,
    22566, 23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392,
    34846, 36327, 37837, 39378, 40951, 42560, 44205, 45889, 47615,
    49385, 51202, 53070, 54991, 56970, 59009, 61113, 63287, 65536
  };

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rlpe_pkg::in_word_t  in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rlpe_pkg::out_word_t out_data;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [2:0]          paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Shadow copy of the registers, as the block should hold them.
  logic [7:0]  bright_pct = rlpe_pkg::BRIGHTNESS_RST;
  logic [16:0] period_cfg = rlpe_pkg::PERIOD_RST;

  rlpe_pkg::in_word_t  led_q[$];
  rlpe_pkg::out_word_t slots_due[$];
  rlpe_pkg::out_word_t want_slot;
  int unsigned leds_queued  = 0;
  int unsigned leds_taken   = 0;
  int unsigned errors       = 0;
  int unsigned idle_cycles  = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  rgb_led_pulse_encoder_top #(
    .PAUSE_SLOTS(PAUSE_LEN)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Expected bit slots of one LED: scale, pack GRB, emit MSB first, then the pause if it ends a frame.
  function automatic void predict_slots(input rlpe_pkg::in_word_t led);
    int unsigned angle, factor, p, zero_duty, one_duty, r, g, b;
    logic [23:0] grb;
    rlpe_pkg::out_word_t slot;
    angle = bright_pct * 45 / 100;
    if (angle > 45) begin
      angle = 45;
    end
    factor = TANGENT_Q16[angle];
    r = (led.red * factor) >> 16;
    g = (led.green * factor) >> 16;
    b = (led.blue * factor) >> 16;
    grb = {g[7:0], r[7:0], b[7:0]};
    p = period_cfg;
    zero_duty = p / 3;
    one_duty = (p * 2) / 3;
    if (zero_duty > 16'hFFFF) begin
      zero_duty = 16'hFFFF;
    end
    if (one_duty > 16'hFFFF) begin
      one_duty = 16'hFFFF;
    end
    for (int i = 23; i >= 0; i--) begin
      slot.duty = grb[i] ? one_duty[15:0] : zero_duty[15:0];
      slot.slot_count = 1;
      slot.run_last = !led.last_led && (i == 0);
      slots_due.push_back(slot);
    end
    if (led.last_led) begin
      slot.duty = '0;
      slot.slot_count = (PAUSE_LEN > 63) ? 63 : PAUSE_LEN;
      slot.run_last = 1'b1;
      slots_due.push_back(slot);
    end
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  // Receiver readiness, stalling at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Driver: present the next queued LED word once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (led_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= led_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted LED, check every accepted slot word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_slots(in_data);
        leds_taken <= leds_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (slots_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got duty %0d slots %0d last %0d",
                   $time, out_data.duty, out_data.slot_count, out_data.run_last);
          errors++;
        end else begin
          want_slot = slots_due.pop_front();
          if (want_slot.duty !== out_data.duty) begin
            report_mismatch("duty", want_slot.duty, out_data.duty);
          end
          if (want_slot.slot_count !== out_data.slot_count) begin
            report_mismatch("slot_count", want_slot.slot_count, out_data.slot_count);
          end
          if (want_slot.run_last !== out_data.run_last) begin
            report_mismatch("run_last", want_slot.run_last, out_data.run_last);
          end
        end
      end
    end
  end

  // Watchdog: a long stretch with no handshake and no register access ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Register write followed by a read back of the same register.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] stored;
    stored = (addr == ADDR_BRIGHTNESS) ? (data & 32'hFF) : (data & 32'h1FFFF);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_BRIGHTNESS) begin
      bright_pct = stored[7:0];
    end else begin
      period_cfg = stored[16:0];
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== stored) begin
      $display("%0t: read back at %0d, expected %0d, got %0d", $time, addr, stored, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic last);
    rlpe_pkg::in_word_t led;
    led.red = r;
    led.green = g;
    led.blue = b;
    led.last_led = last;
    led_q.push_back(led);
    leds_queued++;
  endtask

  // Channel value, biased toward the ends of the range.
  function automatic logic [7:0] rand_level();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return 8'h00;
    end else if (pick == 1) begin
      return 8'hFF;
    end
    return $urandom_range(255);
  endfunction

  // Mostly whole frames of random length; now and then a stray frame end flag.
  task automatic queue_frames(input int unsigned count);
    int unsigned len;
    logic        last;
    while (count > 0) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len && count > 0; k++) begin
        last = (k == len - 1);
        if ($urandom_range(9) == 0) begin
          last = $urandom_range(1);
        end
        queue_led(rand_level(), rand_level(), rand_level(), last);
        count--;
      end
    end
  endtask

  // Hold the sender back until every queued LED is taken and every slot has come.
  task automatic drain();
    while (leds_taken != leds_queued) begin
      @(posedge clk);
    end
    while (slots_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Phases: reset settings first, then extremes and other values of both registers, the last one random.
  initial begin
    int unsigned bright_tab [PHASES];
    int unsigned period_tab [PHASES];
    bright_tab = '{100, 0, 255, 3, 101, 99, 50, 0};
    period_tab = '{90, 3, 65536, 131071, 100000, 2, 0, 0};
    bright_tab[7] = $urandom_range(255);
    period_tab[7] = $urandom_range(3, 65536);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 58;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      if (ph != 0) begin
        write_reg(ADDR_BRIGHTNESS, bright_tab[ph]);
        write_reg(ADDR_PERIOD, period_tab[ph]);
      end
      if (ph == 0) begin
        // Directed words at full brightness: extremes, single channels, frame ends.
        queue_led(8'h00, 8'h00, 8'h00, 1'b0);
        queue_led(8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_led(8'hFF, 8'h00, 8'h00, 1'b1);
        queue_led(8'h00, 8'hFF, 8'h00, 1'b0);
        queue_led(8'h00, 8'h00, 8'hFF, 1'b1);
        queue_led(8'hAA, 8'h55, 8'hAA, 1'b0);
        queue_led(8'h55, 8'hAA, 8'h55, 1'b1);
        queue_led(8'h80, 8'h01, 8'h80, 1'b1);
        queue_led(8'h01, 8'h80, 8'h01, 1'b1);
        queue_led(8'h00, 8'h00, 8'h00, 1'b1);
        queue_led(8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_led(8'h7F, 8'hFE, 8'h7F, 1'b0);
        drain();
      end
      queue_frames(14);
      drain();
      queue_frames(14);
      drain();
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
